@@ design/feps_pkg.sv @@
package feps_pkg;

   localparam int unsigned PAGE_BYTES_DEF = 256;

   localparam logic [7:0] CMD_WREN      = 8'h06;
   localparam logic [7:0] CMD_ERASE_4K  = 8'h20;
   localparam logic [7:0] CMD_ERASE_64K = 8'hd8;
   localparam logic [7:0] CMD_PROGRAM   = 8'h02;
   localparam logic [7:0] CMD_NONE      = 8'h00;

   localparam logic       OP_START = 1'b0;
   localparam logic       OP_STEP  = 1'b1;

   localparam logic       STATUS_OK   = 1'b0;
   localparam logic       STATUS_IDLE = 1'b1;

   localparam logic [2:0] ADDR_BYTES_NONE  = 3'd0;
   localparam logic [2:0] ADDR_BYTES_THREE = 3'd3;
   localparam logic [2:0] ADDR_BYTES_FOUR  = 3'd4;

   localparam logic [32:0] SIZE_64K = 33'h0_0001_0000;
   localparam logic [32:0] SIZE_4K  = 33'h0_0000_1000;

   // one flash command as it leaves the block
   typedef struct packed {
      logic [7:0]  flash_command;
      logic [31:0] flash_address;
      logic [2:0]  address_bytes;
      logic [31:0] data_offset;
      logic [8:0]  data_length;
      logic        last;
      logic        transfer_done;
      logic        status;
   } result_type;

endpackage

@@ design/flash_erase_program_sequencer.sv @@
// Flow: an item is taken into the input register, moves into the compute stage once it is
// accepted, and its first command appears on the rsp_ port in the cycle after that.
// Output: a step emits 1, 2 or 4 commands over the single result port, one per cycle while
// rsp_stall is low; a start item emits no command and is followed by a page-offset
// computation in the reciprocal multiplier, during which the following item waits.
// Reset: synchronous, active high; clears all transfer state and sets four_byte_ff to 1.
module flash_erase_program_sequencer #(
   parameter int unsigned PAGE_BYTES = feps_pkg::PAGE_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_write_enable,
   input  logic        csr_write_data,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [31:0] req_start_address,
   input  logic [31:0] req_total_length,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_flash_command,
   output logic [31:0] rsp_flash_address,
   output logic [2:0]  rsp_address_bytes,
   output logic [31:0] rsp_data_offset,
   output logic [8:0]  rsp_data_length,
   output logic        rsp_last,
   output logic        rsp_transfer_done,
   output logic        rsp_status
);
   import feps_pkg::*;

   // page offset width; a page offset is always below PAGE_BYTES
   localparam int unsigned PW = $clog2(PAGE_BYTES);
   // reciprocal for an exact 32-bit remainder by PAGE_BYTES: q = (a * RECIP) >> SHIFT
   localparam int unsigned SHIFT = 32 + PW;
   localparam logic [32:0] RECIP =
      33'(((64'd1 << SHIFT) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES));
   localparam logic [PW:0]   PAGE_FULL = (PW + 1)'(PAGE_BYTES);
   localparam logic [PW-1:0] PAGE_LOW  = PW'(PAGE_BYTES);
   // page offset of the top of the address space; zero when pages divide it evenly
   localparam logic [PW-1:0] WRAP_OFF  = PW'((64'd1 << 32) % 64'(PAGE_BYTES));

   // ------------------------------------------------------------------
   // input register
   // ------------------------------------------------------------------
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_opcode_ff;
   logic [31:0] s1_address_ff;
   logic [31:0] s1_length_ff;

   // ------------------------------------------------------------------
   // transfer state
   // ------------------------------------------------------------------
   logic          four_byte_ff;
   logic [31:0]   cur_ff, cur_in;
   logic [31:0]   rem_ff, rem_in;
   logic [32:0]   erased_ff, erased_in;
   logic [31:0]   bytes_done_ff, bytes_done_in;
   logic [PW-1:0] page_off_ff, page_off_in;
   // high while the page offset of a freshly loaded start address is being worked out
   logic          calc_ff, calc_in;
   logic [64:0]   prod_ff;

   // ------------------------------------------------------------------
   // result buffer: shifts toward slot 0, which drives the rsp_ port
   // ------------------------------------------------------------------
   result_type  res_ff [4];
   result_type  res_load [4];
   logic [2:0]  cnt_ff, cnt_in;
   logic [2:0]  load_cnt;

   logic        pop;
   logic        take;
   logic        take_step;
   logic        take_start;

   // step datapath
   logic [PW:0]   span;
   logic [PW:0]   wlen;
   logic [31:0]   wlen32;
   logic          done;
   logic [32:0]   page_stop;
   logic [32:0]   range_end;
   logic [32:0]   e64;
   logic [32:0]   e4;
   logic          need_erase;
   logic          big_erase;
   logic [31:0]   erase_addr;
   logic [PW:0]   off_sum;
   logic [PW-1:0] q_low;
   logic [2:0]    abytes;
   logic [32:0]   cur_sum;
   logic [PW-1:0] off_lin;
   logic [PW-1:0] off_next;

   // ------------------------------------------------------------------
   // handshake
   // ------------------------------------------------------------------
   assign pop = (cnt_ff != 3'd0) && !rsp_stall;

   // a start needs no result room; a step needs the buffer empty or draining its last entry
   always_comb begin
      take = 1'b0;
      if (s1_valid_ff && !calc_ff) begin
         if (s1_opcode_ff == OP_START) begin
            take = 1'b1;
         end else begin
            take = (cnt_ff == 3'd0) || ((cnt_ff == 3'd1) && pop);
         end
      end
   end

   assign take_step  = take && (s1_opcode_ff == OP_STEP);
   assign take_start = take && (s1_opcode_ff == OP_START);

   // the input register refills in the same cycle it empties
   assign req_stall   = s1_valid_ff && !take;
   assign s1_valid_in = req_valid ? 1'b1 : (s1_valid_ff && !take);

   // ------------------------------------------------------------------
   // page step datapath
   // ------------------------------------------------------------------
   always_comb begin
      span       = PAGE_FULL - {1'b0, page_off_ff};
      done       = !(32'(span) < rem_ff);
      wlen       = done ? rem_ff[PW:0] : span;
      wlen32     = 32'(wlen);
      page_stop  = {1'b0, cur_ff} + 33'(span);
      range_end  = {1'b0, cur_ff} + {1'b0, rem_ff};
      e64        = {1'b0, cur_ff[31:16], 16'h0000} + SIZE_64K;
      e4         = {1'b0, cur_ff[31:12], 12'h000} + SIZE_4K;
      need_erase = page_stop > erased_ff;
      // a 64K erase needs the block to start at this sector and to end inside the range
      big_erase  = (cur_ff[15:12] == 4'h0) && (e64 <= range_end);
      erase_addr = big_erase ? {cur_ff[31:16], 16'h0000} : {cur_ff[31:12], 12'h000};
      off_sum    = {1'b0, page_off_ff} + wlen;
      cur_sum    = {1'b0, cur_ff} + {1'b0, wlen32};
      off_lin    = (off_sum == PAGE_FULL) ? '0 : off_sum[PW-1:0];
      // on a wrap past the top, shift the offset back by the top's own page offset
      off_next   = !cur_sum[32] ? off_lin :
                   (off_lin >= WRAP_OFF) ? off_lin - WRAP_OFF :
                   off_lin + PAGE_LOW - WRAP_OFF;
      abytes     = four_byte_ff ? ADDR_BYTES_FOUR : ADDR_BYTES_THREE;
      q_low      = prod_ff[SHIFT +: PW];
   end

   // build the commands of one step
   always_comb begin
      result_type wren_r;
      result_type erase_r;
      result_type prog_r;
      result_type idle_r;

      wren_r               = '0;
      wren_r.flash_command = CMD_WREN;
      wren_r.address_bytes = ADDR_BYTES_NONE;
      wren_r.transfer_done = done;
      wren_r.status        = STATUS_OK;

      erase_r               = wren_r;
      erase_r.flash_command = big_erase ? CMD_ERASE_64K : CMD_ERASE_4K;
      erase_r.flash_address = four_byte_ff ? erase_addr : {8'h00, erase_addr[23:0]};
      erase_r.address_bytes = abytes;

      prog_r               = wren_r;
      prog_r.flash_command = CMD_PROGRAM;
      prog_r.flash_address = four_byte_ff ? cur_ff : {8'h00, cur_ff[23:0]};
      prog_r.address_bytes = abytes;
      prog_r.data_offset   = bytes_done_ff;
      prog_r.data_length   = wlen32[8:0];
      prog_r.last          = 1'b1;

      idle_r               = '0;
      idle_r.flash_command = CMD_NONE;
      idle_r.last          = 1'b1;
      idle_r.status        = STATUS_IDLE;

      if (rem_ff == 32'd0) begin
         res_load[0] = idle_r;
         res_load[1] = idle_r;
         res_load[2] = idle_r;
         res_load[3] = idle_r;
         load_cnt    = 3'd1;
      end else if (need_erase) begin
         res_load[0] = wren_r;
         res_load[1] = erase_r;
         res_load[2] = wren_r;
         res_load[3] = prog_r;
         load_cnt    = 3'd4;
      end else begin
         res_load[0] = wren_r;
         res_load[1] = prog_r;
         res_load[2] = prog_r;
         res_load[3] = prog_r;
         load_cnt    = 3'd2;
      end
   end

   // ------------------------------------------------------------------
   // next state
   // ------------------------------------------------------------------
   always_comb begin
      cur_in        = cur_ff;
      rem_in        = rem_ff;
      erased_in     = erased_ff;
      bytes_done_in = bytes_done_ff;
      page_off_in   = page_off_ff;
      calc_in       = 1'b0;

      if (calc_ff) begin
         // finish the remainder: a - q * PAGE_BYTES, only the low bits matter
         page_off_in = cur_ff[PW-1:0] - PW'(q_low * PAGE_LOW);
      end else if (take_start) begin
         cur_in        = s1_address_ff;
         rem_in        = s1_length_ff;
         erased_in     = {1'b0, s1_address_ff};
         bytes_done_in = 32'd0;
         calc_in       = 1'b1;
      end else if (take_step && (rem_ff != 32'd0)) begin
         if (need_erase) begin
            erased_in = big_erase ? e64 : e4;
         end
         rem_in        = rem_ff - wlen32;
         cur_in        = cur_sum[31:0];
         bytes_done_in = bytes_done_ff + wlen32;
         page_off_in   = off_next;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (take_step) begin
         cnt_in = load_cnt;
      end else if (pop) begin
         cnt_in = cnt_ff - 3'd1;
      end
   end

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         four_byte_ff  <= 1'b1;
         cur_ff        <= '0;
         rem_ff        <= '0;
         erased_ff     <= '0;
         bytes_done_ff <= '0;
         page_off_ff   <= '0;
         calc_ff       <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         cur_ff        <= cur_in;
         rem_ff        <= rem_in;
         erased_ff     <= erased_in;
         bytes_done_ff <= bytes_done_in;
         page_off_ff   <= page_off_in;
         calc_ff       <= calc_in;
         cnt_ff        <= cnt_in;
         if (csr_write_enable) begin
            four_byte_ff <= csr_write_data;
         end
      end
   end

   // payload: capture the request when the input register is free, advance the buffer
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_opcode_ff  <= req_opcode;
         s1_address_ff <= req_start_address;
         s1_length_ff  <= req_total_length;
      end
      // start of the page-offset remainder: one wide product, registered
      if (take_start) begin
         prod_ff <= 65'(s1_address_ff) * 65'(RECIP);
      end
      if (take_step) begin
         res_ff <= res_load;
      end else if (pop) begin
         res_ff[0] <= res_ff[1];
         res_ff[1] <= res_ff[2];
         res_ff[2] <= res_ff[3];
      end
   end

   // ------------------------------------------------------------------
   // outputs
   // ------------------------------------------------------------------
   assign rsp_valid         = (cnt_ff != 3'd0);
   assign rsp_flash_command = res_ff[0].flash_command;
   assign rsp_flash_address = res_ff[0].flash_address;
   assign rsp_address_bytes = res_ff[0].address_bytes;
   assign rsp_data_offset   = res_ff[0].data_offset;
   assign rsp_data_length   = res_ff[0].data_length;
   assign rsp_last          = res_ff[0].last;
   assign rsp_transfer_done = res_ff[0].transfer_done;
   assign rsp_status        = res_ff[0].status;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   a_cnt_range : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'd4)
      else $error("result count out of range");

   a_step_gives_result : assert property (@(posedge clock) disable iff (reset)
      take_step |=> rsp_valid)
      else $error("accepted step produced no result");

   a_last_is_final : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (cnt_ff == 3'd1))
      else $error("last flag on a result that is not the final one");

   a_offset_in_page : assert property (@(posedge clock) disable iff (reset)
      !calc_ff |-> ({1'b0, page_off_ff} < PAGE_FULL))
      else $error("page offset beyond page size");

   a_no_take_while_calc : assert property (@(posedge clock) disable iff (reset)
      calc_ff |-> !take)
      else $error("item taken during page offset computation");

endmodule
